[design/mersenne_twister_bounded_draw_macros.svh]
// assertion helpers for the generator rtl file
`ifndef MERSENNE_TWISTER_BOUNDED_DRAW_MACROS_SVH
`define MERSENNE_TWISTER_BOUNDED_DRAW_MACROS_SVH

// same-cycle implication, checked while out of reset
`define MTBD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked while out of reset
`define MTBD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/mtbd_pkg.sv]
`default_nettype none

package mtbd_pkg;

    localparam int unsigned STATE_WORDS  = 624;
    localparam int unsigned TWIST_OFFSET = 397;
    localparam int unsigned IDX_W        = $clog2(STATE_WORDS);

    localparam logic [31:0] SEED_MULT    = 32'd1812433253;
    localparam logic [31:0] TEMPER_B     = 32'h9d2c_5680;
    localparam logic [31:0] TEMPER_C     = 32'hefc6_0000;
    localparam logic [31:0] TWIST_MATRIX = 32'h9908_b0df;
    localparam logic [31:0] SEED_RESET   = 32'd5489;

    typedef enum logic [1:0] {
        FUNC_RESEED  = 2'd0,
        FUNC_DRAW    = 2'd1,
        FUNC_BOUNDED = 2'd2
    } t_func;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEED0,
        S_SEED_MUL,
        S_SEED_WR,
        S_RD,
        S_TW,
        S_TM,
        S_FIN
    } t_state;

    // tempering with arithmetic right shifts, then negated when the top bit is set
    function automatic logic [31:0] temper(input logic [31:0] w);
        logic [31:0] y;
        y = w ^ 32'($signed(w) >>> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ 32'($signed(y) >>> 18);
        if (y[31]) begin
            y = 32'd0 - y;
        end
        return y;
    endfunction

    // all ones up to the top set bit of r
    function automatic logic [30:0] span_of(input logic [30:0] r);
        logic [30:0] s;
        s = r;
        s = s | (s >> 1);
        s = s | (s >> 2);
        s = s | (s >> 4);
        s = s | (s >> 8);
        s = s | (s >> 16);
        return s;
    endfunction

endpackage

`default_nettype wire

[design/mtbd_ram.sv]
`default_nettype none

module mtbd_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 624
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_waddr,
    input  wire [WIDTH-1:0]         i_wdata,
    input  wire [$clog2(DEPTH)-1:0] i_raddr_a,
    output logic [WIDTH-1:0]        o_rdata_a,
    input  wire [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]        o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

`default_nettype wire

[design/mersenne_twister_bounded_draw.sv]
`default_nettype none

// MT19937-style generator with bounded draws. Items arrive on the slave stream with
// the function code in tuser (reseed, raw draw, bounded draw) and range and offset
// in tdata; every item returns exactly one 32-bit item on the master stream. The
// 624 state words live in a two-read, one-write RAM; each draw reads the next and
// the far word, twists the current slot in place, tempers it and, for a bounded
// draw, checks it against the range. A draw runs the read, twist/write, temper and
// check steps around the state RAM, and a bounded draw repeats them for every
// rejected word. A reseed writes word 0, then runs a multiply step and a write step
// for each of the other 623 words, and then the final output step. The slave side
// is ready only while idle, so a new item is accepted only once the last one is
// finished. A draw issued before any seeding first runs a reseed from the seed
// register. The seed register is written through the config channel, which is
// always ready; write it only while the block is idle.
// A finished item waits in the output register while the next one is accepted.

`include "mersenne_twister_bounded_draw_macros.svh"

module mersenne_twister_bounded_draw (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // config write channel: seed_value
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [31:0] i_cfg_data,
    // input items
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [63:0] i_s_axis_tdata,   // range[30:0], offset[62:31], zero pad [63]
    input  wire  [1:0]  i_s_axis_tuser,   // func[1:0]
    // result items
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata    // value[31:0]
);

    import mtbd_pkg::*;

    // fsm and control
    t_state             r_state, n_state;
    t_func              r_func;
    logic               r_seeded;
    logic [IDX_W-1:0]   r_idx;      // slot to twist next
    logic [IDX_W-1:0]   r_k;        // seeding word counter

    // item payload
    logic [30:0]        r_range;
    logic [30:0]        r_span;
    logic [31:0]        r_offset;
    logic [31:0]        r_seed;

    // datapath
    logic [31:0]        r_prev;     // last seeded word
    logic [31:0]        r_prod;     // seeding product
    logic [31:0]        r_cur;      // cached copy of the word at r_idx
    logic [31:0]        r_word;     // freshly twisted word
    logic [31:0]        r_y;        // tempered word

    // output register
    logic               r_out_valid;
    logic [31:0]        r_out_data;

    // ram ports
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    logic [31:0]        mem_wdata;
    logic [IDX_W-1:0]   mem_raddr_a;
    logic [IDX_W-1:0]   mem_raddr_b;
    logic [31:0]        mem_rdata_a;
    logic [31:0]        mem_rdata_b;

    logic               in_acc;
    logic               out_load;
    logic               redraw;
    logic               seed_last;
    logic [IDX_W-1:0]   idx_nx;
    logic [IDX_W-1:0]   idx_far;
    logic [IDX_W:0]     far_sum;
    logic [31:0]        seed_word;
    logic [31:0]        twisted;
    logic [31:0]        mix;
    logic [30:0]        masked;
    logic [31:0]        result;

    mtbd_ram #(
        .WIDTH (32),
        .DEPTH (STATE_WORDS)
    ) u_state_ram (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_waddr   (mem_waddr),
        .i_wdata   (mem_wdata),
        .i_raddr_a (mem_raddr_a),
        .o_rdata_a (mem_rdata_a),
        .i_raddr_b (mem_raddr_b),
        .o_rdata_b (mem_rdata_b)
    );

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    assign in_acc = i_s_axis_tvalid && o_s_axis_tready;

    // neighbor and far slots with wraparound
    assign idx_nx  = (r_idx == IDX_W'(STATE_WORDS - 1)) ? '0 : r_idx + IDX_W'(1);
    assign far_sum = {1'b0, r_idx} + (IDX_W + 1)'(TWIST_OFFSET);
    assign idx_far = (far_sum >= (IDX_W + 1)'(STATE_WORDS))
                   ? IDX_W'(far_sum - (IDX_W + 1)'(STATE_WORDS))
                   : far_sum[IDX_W-1:0];

    // seed recurrence: product registered, index added on the write step
    assign seed_word = r_prod + {{(32 - IDX_W){1'b0}}, r_k};
    assign seed_last = (r_k == IDX_W'(STATE_WORDS - 1));

    // twist of the current slot
    assign mix     = {r_cur[31], mem_rdata_a[30:0]};
    assign twisted = mem_rdata_b ^ (mix >> 1) ^ (mem_rdata_a[0] ? TWIST_MATRIX : 32'd0);

    // bounded draw check
    assign masked = r_y[30:0] & r_span;
    assign redraw = (r_func == FUNC_BOUNDED) && (r_range != '0) && (masked >= r_range);

    always_comb begin
        unique case (r_func)
            FUNC_DRAW:    result = r_y;
            FUNC_BOUNDED: result = (r_range == '0) ? r_y : ({1'b0, masked} + r_offset);
            default:      result = 32'd0;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    priority case (i_s_axis_tuser)
                        FUNC_RESEED:  n_state = S_SEED0;
                        FUNC_DRAW,
                        FUNC_BOUNDED: n_state = r_seeded ? S_RD : S_SEED0;
                        default:      n_state = S_FIN;
                    endcase
                end
            end
            S_SEED0:    n_state = S_SEED_MUL;
            S_SEED_MUL: n_state = S_SEED_WR;
            S_SEED_WR: begin
                if (seed_last) begin
                    n_state = (r_func == FUNC_RESEED) ? S_FIN : S_RD;
                end else begin
                    n_state = S_SEED_MUL;
                end
            end
            S_RD: n_state = S_TW;
            S_TW: n_state = S_TM;
            S_TM: n_state = S_FIN;
            S_FIN: begin
                if (redraw) begin
                    n_state = S_RD;
                end else if (!r_out_valid || i_m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        mem_we      = 1'b0;
        mem_waddr   = r_idx;
        mem_wdata   = twisted;
        mem_raddr_a = idx_nx;
        mem_raddr_b = idx_far;
        out_load    = 1'b0;
        unique case (r_state)
            S_SEED0: begin
                mem_we    = 1'b1;
                mem_waddr = '0;
                mem_wdata = r_seed;
            end
            S_SEED_WR: begin
                mem_we    = 1'b1;
                mem_waddr = r_k;
                mem_wdata = seed_word;
            end
            S_TW: begin
                mem_we = 1'b1;
            end
            S_FIN: begin
                out_load = !redraw && (!r_out_valid || i_m_axis_tready);
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_seeded    <= 1'b0;
            r_idx       <= '0;
            r_k         <= '0;
            r_func      <= FUNC_RESEED;
            r_seed      <= SEED_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_seed <= i_cfg_data;
            end
            if (in_acc) begin
                r_func <= t_func'(i_s_axis_tuser);
            end
            if (r_state == S_SEED0) begin
                r_k <= IDX_W'(1);
            end else if (r_state == S_SEED_WR) begin
                r_k <= r_k + IDX_W'(1);
                if (seed_last) begin
                    r_idx    <= '0;
                    r_seeded <= 1'b1;
                end
            end else if (r_state == S_TW) begin
                r_idx <= idx_nx;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_range  <= i_s_axis_tdata[30:0];
            r_offset <= i_s_axis_tdata[62:31];
            r_span   <= span_of(i_s_axis_tdata[30:0]);
        end
        unique case (r_state)
            S_SEED0: begin
                r_prev <= r_seed;
                r_cur  <= r_seed;
            end
            S_SEED_MUL: begin
                r_prod <= 32'(SEED_MULT * (r_prev ^ (r_prev >> 30)));
            end
            S_SEED_WR: begin
                r_prev <= seed_word;
            end
            S_TW: begin
                r_word <= twisted;
                r_cur  <= mem_rdata_a;
            end
            S_TM: begin
                r_y <= temper(r_word);
            end
            default: begin
            end
        endcase
        if (out_load) begin
            r_out_data <= result;
        end
    end

    `MTBD_ASSERT_NOW(a_write_states, i_clk, i_rst_n, mem_we,
        (r_state == S_SEED0) || (r_state == S_SEED_WR) || (r_state == S_TW),
        "state ram written outside seeding or twist")
    `MTBD_ASSERT_NOW(a_draw_seeded, i_clk, i_rst_n, (r_state == S_RD),
        r_seeded && (r_idx < IDX_W'(STATE_WORDS)),
        "draw started on unseeded store or bad index")
    `MTBD_ASSERT_NOW(a_seed_count, i_clk, i_rst_n, (r_state == S_SEED_WR),
        (r_k != '0) && (r_k < IDX_W'(STATE_WORDS)),
        "seeding counter out of range")
    `MTBD_ASSERT_NEXT(a_twist_advance, i_clk, i_rst_n, (r_state == S_TW),
        (r_idx == $past(idx_nx)) && (r_state == S_TM),
        "twist did not advance the slot index")

endmodule

`default_nettype wire
